// File: hw/rtl/median_filter_5x5_unit_defines.svh
// assertion macros for the median filter unit
`ifndef MEDIAN_FILTER_5X5_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_5X5_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define MF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mf5_pkg.sv
// ----------------------------------------------------------------------------
// mf5_pkg
// shared constants and types of the 5x5 median filter
// ----------------------------------------------------------------------------
package mf5_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WINDOW_SIZE_DEF = 5;
  localparam int MAX_HEIGHT      = 1024;
  localparam int DIM_W           = 11;
  localparam int PIX_W           = 8;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // beat handed from the front part to the back part
  typedef struct packed {
    logic             row_end;
    logic             frame_end;
    logic             emit;
  } mf5_tag_t;

endpackage

// File: hw/rtl/median_filter_5x5_unit.sv
// ----------------------------------------------------------------------------
// median_filter_5x5_unit
// streaming 5x5 median filter over 8-bit grey raster pixels
// ----------------------------------------------------------------------------
// One pixel is taken per clock while in_tready is high. The line stores are
// read at the pixel beat and the window register is loaded in the cycle after;
// the result then passes the rank-count and select stages and is written into
// an 8-entry queue, offered on out_tvalid from then on.
// in_tready drops only while the queue plus the beats in flight could overfill
// it, so throughput is one beat per cycle while the output side takes beats.
// Results exist only for window centres lying fully inside the frame. The line
// stores need no clearing pass.
module median_filter_5x5_unit import mf5_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // median_value, row_end, frame_end, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam int QD = 8;

  logic [DIM_W-1:0] frame_width_r, frame_height_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(640);
      frame_height_r <= DIM_W'(480);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic step;
  logic win_vld;
  mf5_tag_t win_tag;
  logic [WINDOW_SIZE*WINDOW_SIZE*PIX_W-1:0] win;
  logic srt_vld;
  mf5_tag_t srt_tag;
  logic [PIX_W-1:0] srt_med;
  logic [$clog2(QD):0] q_count;
  logic q_vld, q_rd;
  logic [PIX_W+1:0] q_data;

  // up to four beats in flight; keep room for them and the new one
  assign in_tready = (q_count <= ($clog2(QD)+1)'(QD - 5));
  assign step = in_tvalid && in_tready;

  mf5_front #(.MAX_WIDTH(MAX_WIDTH), .WINDOW_SIZE(WINDOW_SIZE)) u_front (
    .clk, .rst_n, .step,
    .pixel(in_tdata), .frame_start(in_tuser),
    .frame_width(frame_width_r), .frame_height(frame_height_r),
    .win_vld_r(win_vld), .win_tag_r(win_tag), .win_r(win)
  );

  mf5_sort #(.WINDOW_SIZE(WINDOW_SIZE)) u_sort (
    .clk, .rst_n, .in_vld(win_vld), .in_tag(win_tag), .in_win(win),
    .out_vld_r(srt_vld), .out_tag_r(srt_tag), .out_med_r(srt_med)
  );

  mf5_queue #(.DEPTH(QD)) u_queue (
    .clk, .rst_n, .wr_en(srt_vld),
    .wr_data({srt_tag.frame_end, srt_tag.row_end, srt_med}),
    .count_r(q_count), .rd_vld(q_vld), .rd_en(q_rd), .rd_data(q_data)
  );

  assign q_rd       = q_vld && out_tready;
  assign out_tvalid = q_vld;
  assign out_tdata  = {6'b0, q_data};

endmodule

// File: hw/rtl/mf5_front.sv
// ----------------------------------------------------------------------------
// mf5_front
// position tracking, line stores and window shift; while step is high, one pixel per cycle
// ----------------------------------------------------------------------------
module mf5_front import mf5_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  frame_start,
  input  logic [DIM_W-1:0]      frame_width,
  input  logic [DIM_W-1:0]      frame_height,
  output logic                  win_vld_r,
  output mf5_tag_t              win_tag_r,
  output logic [WINDOW_SIZE*WINDOW_SIZE*PIX_W-1:0] win_r
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int NL  = WINDOW_SIZE - 1;
  localparam int CMW = (CW > DIM_W) ? CW : DIM_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CMW-1:0] w_use;
  logic [DIM_W-1:0] h_use;
  logic [CW-1:0] c0, c;
  logic [RW-1:0] r0, r;
  logic           last_col;
  mf5_tag_t       tag_nxt;

  // clamp the registered dimensions
  always_comb begin
    if (CMW'(frame_width) < CMW'(WINDOW_SIZE)) w_use = CMW'(WINDOW_SIZE);
    else if (CMW'(frame_width) > CMW'(MAX_WIDTH)) w_use = CMW'(MAX_WIDTH);
    else w_use = CMW'(frame_width);
    if (frame_height < DIM_W'(WINDOW_SIZE)) h_use = DIM_W'(WINDOW_SIZE);
    else if (frame_height > DIM_W'(MAX_HEIGHT)) h_use = DIM_W'(MAX_HEIGHT);
    else h_use = frame_height;
  end

  // position of this pixel and of the next one
  always_comb begin
    c0 = frame_start ? '0 : col_r;
    r0 = frame_start ? '0 : row_r;
    if (CMW'(c0) >= w_use) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (DIM_W'(r0) >= h_use) r0 = '0;
    c = c0;
    r = r0;
    last_col = (CMW'(c) == w_use - 1'b1);
    col_nxt = c + 1'b1;
    row_nxt = r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = r + 1'b1;
      if (DIM_W'(row_nxt) >= h_use) row_nxt = '0;
    end
  end

  // marks of this pixel
  always_comb begin
    tag_nxt.emit      = (r >= RW'(NL)) && (c >= CW'(NL));
    tag_nxt.row_end   = last_col;
    tag_nxt.frame_end = last_col && (DIM_W'(r) == h_use - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: one column of NL pixels per address; read at the beat,
  // written back in the following cycle with the pending write forwarded
  logic [NL*PIX_W-1:0] ls_mem [MAX_WIDTH];
  logic [NL*PIX_W-1:0] ls_rd_r;
  logic [NL*PIX_W-1:0] ls_wr;
  logic [AW-1:0]       addr;
  logic [AW-1:0]       p1_addr_r;
  logic [PIX_W-1:0]    p1_pix_r;
  logic                p1_vld_r;
  mf5_tag_t            p1_tag_r;

  assign addr  = c[AW-1:0];
  assign ls_wr = {ls_rd_r[(NL-1)*PIX_W-1:0], p1_pix_r};

  always_ff @(posedge clk) begin
    if (p1_vld_r) ls_mem[p1_addr_r] <= ls_wr;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (p1_vld_r && (p1_addr_r == addr)) ls_rd_r <= ls_wr;
      else ls_rd_r <= ls_mem[addr];
    end
  end

  // pixel stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else p1_vld_r <= step;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      p1_addr_r <= addr;
      p1_pix_r  <= pixel;
      p1_tag_r  <= tag_nxt;
    end
  end

  // window shift; cell (y,x) sits at index y*WINDOW_SIZE+x
  logic [WINDOW_SIZE*WINDOW_SIZE*PIX_W-1:0] win_nxt;
  always_comb begin
    for (int y = 0; y < WINDOW_SIZE; y++) begin
      for (int x = 0; x < WINDOW_SIZE - 1; x++) begin
        win_nxt[(y*WINDOW_SIZE+x)*PIX_W +: PIX_W] =
          win_r[(y*WINDOW_SIZE+x+1)*PIX_W +: PIX_W];
      end
    end
    for (int k = 0; k < NL; k++) begin
      win_nxt[((WINDOW_SIZE-2-k)*WINDOW_SIZE+WINDOW_SIZE-1)*PIX_W +: PIX_W] =
        ls_rd_r[k*PIX_W +: PIX_W];
    end
    win_nxt[(WINDOW_SIZE*WINDOW_SIZE-1)*PIX_W +: PIX_W] = p1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (p1_vld_r) win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= 1'b0;
      win_tag_r <= '0;
    end else begin
      win_vld_r <= p1_vld_r && p1_tag_r.emit;
      if (p1_vld_r) win_tag_r <= p1_tag_r;
    end
  end

endmodule

// File: hw/rtl/mf5_sort.sv
// ----------------------------------------------------------------------------
// mf5_sort
// pipelined rank selection: the first stage ranks every window element by compares
// ----------------------------------------------------------------------------
module mf5_sort import mf5_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  mf5_tag_t              in_tag,
  input  logic [WINDOW_SIZE*WINDOW_SIZE*PIX_W-1:0] in_win,
  output logic                  out_vld_r,
  output mf5_tag_t              out_tag_r,
  output logic [PIX_W-1:0]      out_med_r
);

  localparam int N    = WINDOW_SIZE * WINDOW_SIZE;
  localparam int RANK = N / 2;
  localparam int KW   = $clog2(N + 1);

  // stage 1: per element counts of smaller and of smaller-or-equal values
  logic [KW-1:0] lt_nxt [N];
  logic [KW-1:0] le_nxt [N];
  logic [KW-1:0] lt_r [N];
  logic [KW-1:0] le_r [N];
  logic [N*PIX_W-1:0] win_s1_r;
  logic               vld_s1_r;
  mf5_tag_t           tag_s1_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      lt_nxt[i] = '0;
      le_nxt[i] = '0;
      for (int j = 0; j < N; j++) begin
        lt_nxt[i] = lt_nxt[i] + KW'(in_win[j*PIX_W +: PIX_W] < in_win[i*PIX_W +: PIX_W]);
        le_nxt[i] = le_nxt[i] + KW'(in_win[j*PIX_W +: PIX_W] <= in_win[i*PIX_W +: PIX_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      lt_r[i] <= lt_nxt[i];
      le_r[i] <= le_nxt[i];
    end
    win_s1_r <= in_win;
    tag_s1_r <= in_tag;
  end

  // stage 2: pick an element whose rank range covers the median rank
  logic [PIX_W-1:0] med_nxt;
  always_comb begin
    med_nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (lt_r[i] <= KW'(RANK) && le_r[i] > KW'(RANK))
        med_nxt = win_s1_r[i*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_s1_r  <= in_vld;
      out_vld_r <= vld_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    out_med_r <= med_nxt;
    out_tag_r <= tag_s1_r;
  end

endmodule

// File: hw/rtl/mf5_queue.sv
// ----------------------------------------------------------------------------
// mf5_queue
// result queue between the window pipeline and the output port
// ----------------------------------------------------------------------------
module mf5_queue import mf5_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [PIX_W+1:0] wr_data,
  output logic [$clog2(DEPTH):0] count_r,
  output logic             rd_vld,
  input  logic             rd_en,
  output logic [PIX_W+1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [PIX_W+1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;

  assign rd_vld  = (count_r != '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      count_r <= count_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

// File: hw/rtl/mf5_checker.sv
// ----------------------------------------------------------------------------
// mf5_checker
// port-level checks of the median filter unit
// ----------------------------------------------------------------------------
`include "median_filter_5x5_unit_defines.svh"

module mf5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // stalled result beat must hold
  `MF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "out beat dropped")
  // frame end only on a row end
  `MF_ASSERT_IMP(a_fend_row, out_tvalid && out_tdata[9], out_tdata[8], "frame end without row end")
  // zero fill stays zero
  `MF_ASSERT_IMP(a_fill, out_tvalid, out_tdata[15:10] == 6'b0, "fill bits set")

endmodule

bind median_filter_5x5_unit mf5_checker u_mf5_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
